>>> src/lse_pkg.sv
// Package for the LED strip effect generator: payload types, codes, constants.
// No dependencies.
package lse_pkg;

	localparam int LedCount = 84;
	localparam int RingLast = 3 * (LedCount - 1);
	localparam logic [31:0] LfsrPoly = 32'h04C11DB7;
	localparam logic [31:0] LfsrReset = 32'd64738;
	localparam logic [7:0] NoSparkle = 8'hFF;
	localparam int BakAw = $clog2(LedCount);

	typedef enum logic [2:0] {
		TGT_COLOUR = 3'd0,
		TGT_POINTER = 3'd1,
		TGT_INTENSITY = 3'd2,
		TGT_ENABLE = 3'd3,
		TGT_TRIGGER = 3'd4
	} target_t;

	typedef enum logic [2:0] {
		MODE_OFF = 3'd0,
		MODE_FIXED = 3'd1,
		MODE_MUSIC = 3'd2,
		MODE_RAINBOW = 3'd3,
		MODE_SPARKLE = 3'd4
	} mode_t;

	localparam logic [1:0] REG_MODE = 2'd0;
	localparam logic [1:0] REG_COLOR = 2'd1;
	localparam logic [1:0] REG_TINT = 2'd2;
	localparam logic [1:0] REG_BRIGHT = 2'd3;

	typedef struct packed {
		logic [7:0] voice_level_a;
		logic [7:0] voice_level_b;
		logic [7:0] voice_level_c;
	} in_item_t;

	typedef struct packed {
		logic [2:0] write_target;
		logic [7:0] write_address;
		logic [7:0] write_value;
		logic       last_write;
	} out_item_t;

	function automatic logic [7:0] white_mix(input logic [1:0] sel);
		logic [7:0] r;
		unique case (sel)
			2'd0: r = 8'd0;
			2'd1: r = 8'd50;
			2'd2: r = 8'd100;
			default: r = 8'd170;
		endcase
		return r;
	endfunction

endpackage

>>> src/led_strip_effect_generator.sv
// Top level of the LED strip effect generator: APB registers, colour sequencer,
// backup memory and write emitter. Depends on lse_pkg.
// The first write follows the colour passes, if any, of one shared 8x8 multiplier;
// writes then leave one per cycle while out_ready is high. in_ready is low from an
// accepted tick until its last write is taken. Reset: registers take reset values,
// then the S_CLEAR state clears the backup before the first tick is taken.
module led_strip_effect_generator (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  lse_pkg::in_item_t    in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output lse_pkg::out_item_t   out_data,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [3:0]           paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready
);
	import lse_pkg::*;

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_WHEEL, S_MUL, S_DIV, S_NEXT, S_BAKRD, S_BAKWAIT,
		S_SPARK, S_EMIT
	} state_t;

	state_t state_q;
	logic [2:0] mode_q;
	logic [4:0] color_q, bright_q;
	logic [1:0] tint_q;
	logic [7:0] ring_q, sled_q, fade_q;
	logic [9:0] step_q;
	logic [31:0] lfsr_q;

	// colour working registers: chan 0 r, 1 g, 2 b
	logic [7:0] col_q [3];
	logic [1:0] ch_q;
	logic [1:0] pass_q;   // 0 tint, 1 fade, 2 scale
	logic [16:0] acc_q;
	logic [7:0] va_q, vb_q, vc_q;

	// write list
	out_item_t wl_q [13];
	logic [3:0] wn_q, wi_q;

	// backup memory
	logic [23:0] bak_mem [LedCount];
	logic [23:0] bak_rd_q;
	logic [BakAw-1:0] clr_q;

	// register port
	assign pready = 1'b1;
	always_comb begin
		unique case (paddr[3:2])
			REG_MODE: prdata = {29'd0, mode_q};
			REG_COLOR: prdata = {27'd0, color_q};
			REG_TINT: prdata = {30'd0, tint_q};
			default: prdata = {27'd0, bright_q};
		endcase
	end

	// wheel colour for the current hue
	logic [10:0] h;
	logic [7:0] f;
	logic [7:0] wr, wg, wb;
	always_comb begin
		if (mode_q == MODE_FIXED)
			h = {color_q, 6'd0};  // idx*1536/24 = idx*64
		else
			h = {step_q, 1'b0};   // idx*1536/768 = idx*2
		f = h[7:0];
		unique case (h[10:8])
			3'd0: begin wr = 8'd255; wg = f; wb = 8'd0; end
			3'd1: begin wr = 8'd255 - f; wg = 8'd255; wb = 8'd0; end
			3'd2: begin wr = 8'd0; wg = 8'd255; wb = f; end
			3'd3: begin wr = 8'd0; wg = 8'd255 - f; wb = 8'd255; end
			3'd4: begin wr = f; wg = 8'd0; wb = 8'd255; end
			default: begin wr = 8'd255; wg = 8'd0; wb = 8'd255 - f; end
		endcase
	end

	// shared multiplier: blend c*(255-t)+255*t+127, or scale c*b
	logic [7:0] t_sel, c_cur;
	logic [16:0] mul_out;
	always_comb begin
		c_cur = col_q[ch_q];
		unique case (pass_q)
			2'd0: t_sel = white_mix(tint_q);
			2'd1: t_sel = fade_q;
			default: t_sel = {3'd0, bright_q};
		endcase
		if (pass_q == 2'd2)
			mul_out = 17'(c_cur) * 17'(t_sel);
		else
			mul_out = 17'(c_cur) * 17'(8'd255 - t_sel) + 17'(t_sel) * 17'd255 + 17'd127;
	end

	// divide by 255 for values below 65280: q = (x + (x>>8) + 1) >> 8
	logic [17:0] dsum;
	logic [7:0] dq;
	always_comb begin
		dsum = 18'(acc_q) + 18'(acc_q[16:8]) + 18'd1;
		dq = dsum[15:8];
	end

	logic [7:0] next_ring;
	assign next_ring = (ring_q < 8'd3) ? 8'(RingLast) : ring_q - 8'd3;
	logic [31:0] lfsr_nx;
	assign lfsr_nx = lfsr_q[31] ? ((lfsr_q << 1) ^ LfsrPoly) : (lfsr_q << 1);
	// new sparkle when the low 13 LFSR bits name an LED
	logic spark_new;
	assign spark_new = (lfsr_nx[12:8] == 5'd0) && (lfsr_nx[7:0] < 8'(LedCount));
	logic [7:0] new_base;
	assign new_base = (lfsr_nx[7:0] << 1) + lfsr_nx[7:0];

	// previous sparkle to restore, if one is lit
	logic restore;
	assign restore = (sled_q < 8'(LedCount));
	logic [7:0] sled_base;
	assign sled_base = (sled_q << 1) + sled_q;
	logic [BakAw-1:0] rd_idx;
	assign rd_idx = restore ? sled_q[BakAw-1:0] : '0;

	// LED of the ring position: ring/3 as (ring*171)>>9, exact below 256
	logic [15:0] kmul;
	logic [BakAw-1:0] k_ring;
	assign kmul = 16'(ring_q) * 16'd171;
	assign k_ring = kmul[9 +: BakAw];

	function automatic out_item_t mk(input target_t t, input logic [7:0] a,
		input logic [7:0] v);
		out_item_t o;
		o.write_target = t;
		o.write_address = a;
		o.write_value = v;
		o.last_write = 1'b0;
		return o;
	endfunction

	assign in_ready = (state_q == S_IDLE);
	assign out_valid = (state_q == S_EMIT);
	always_comb begin
		out_data = wl_q[wi_q];
		out_data.last_write = (wi_q == wn_q - 4'd1);
	end

	// backup memory port
	always_ff @(posedge clk) begin
		if (state_q == S_CLEAR)
			bak_mem[clr_q] <= '0;
		else if (state_q == S_BAKRD && mode_q == MODE_SPARKLE && ring_q < 8'(3 * LedCount))
			bak_mem[k_ring] <= {col_q[1], col_q[0], col_q[2]};
		if (state_q == S_BAKWAIT)
			bak_rd_q <= bak_mem[rd_idx];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			mode_q <= 3'd1; color_q <= 5'd15; tint_q <= 2'd0; bright_q <= 5'd9;
			ring_q <= '0; step_q <= '0; lfsr_q <= LfsrReset; sled_q <= '0;
			fade_q <= 8'd255; clr_q <= '0; wn_q <= '0; wi_q <= '0;
			ch_q <= '0; pass_q <= '0;
		end else begin
			// hold register writes
			if (psel && penable && pwrite) begin
				unique case (paddr[3:2])
					REG_MODE: mode_q <= pwdata[2:0];
					REG_COLOR: color_q <= pwdata[4:0];
					REG_TINT: tint_q <= pwdata[1:0];
					default: bright_q <= pwdata[4:0];
				endcase
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == BakAw'(LedCount - 1)) state_q <= S_IDLE;
				end
				S_IDLE: if (in_valid) begin
					va_q <= in_data.voice_level_a;
					vb_q <= in_data.voice_level_b;
					vc_q <= in_data.voice_level_c;
					if (mode_q == MODE_RAINBOW || mode_q == MODE_SPARKLE)
						step_q <= (step_q == 10'd767) ? '0 : step_q + 1'b1;
					state_q <= S_WHEEL;
				end
				S_WHEEL: begin
					if (mode_q == MODE_FIXED && color_q >= 5'd24) begin
						col_q[0] <= 8'd255; col_q[1] <= 8'd255; col_q[2] <= 8'd255;
					end else begin
						col_q[0] <= wr; col_q[1] <= wg; col_q[2] <= wb;
					end
					ch_q <= '0; pass_q <= '0;
					if (mode_q == MODE_FIXED || mode_q == MODE_RAINBOW ||
						mode_q == MODE_SPARKLE)
						state_q <= S_MUL;
					else
						state_q <= S_BAKRD;
				end
				S_MUL: begin
					acc_q <= mul_out;
					state_q <= S_DIV;
				end
				S_DIV: begin
					col_q[ch_q] <= (pass_q == 2'd2) ? acc_q[12:5] : dq;
					if (ch_q != 2'd2) begin
						ch_q <= ch_q + 1'b1;
						state_q <= S_MUL;
					end else begin
						ch_q <= '0;
						state_q <= S_NEXT;
					end
				end
				S_NEXT: begin
					// choose the next pass or finish colour
					if (pass_q == 2'd0 && mode_q == MODE_RAINBOW && fade_q != 8'd0) begin
						pass_q <= 2'd1; state_q <= S_MUL;
					end else if (pass_q == 2'd0 && mode_q != MODE_RAINBOW) begin
						pass_q <= 2'd2; state_q <= S_MUL;
					end else begin
						state_q <= S_BAKRD;
					end
				end
				S_BAKRD: begin
					state_q <= S_BAKWAIT;
				end
				S_BAKWAIT: begin
					wi_q <= '0;
					state_q <= (mode_q == MODE_SPARKLE) ? S_SPARK : S_EMIT;
					unique case (mode_q)
						MODE_FIXED: begin
							ring_q <= '0;
							wl_q[0] <= mk(TGT_ENABLE, 8'd0, 8'd1);
							wl_q[1] <= mk(TGT_INTENSITY, 8'd0, {1'b0, bright_q, 2'b00});
							wl_q[2] <= mk(TGT_COLOUR, 8'd0, col_q[1]);
							wl_q[3] <= mk(TGT_COLOUR, 8'd1, col_q[0]);
							wl_q[4] <= mk(TGT_COLOUR, 8'd2, col_q[2]);
							wl_q[5] <= mk(TGT_POINTER, 8'd0, 8'd0);
							wl_q[6] <= mk(TGT_TRIGGER, 8'd0, 8'd0);
							wn_q <= 4'd7;
						end
						MODE_MUSIC, MODE_RAINBOW: begin
							wl_q[0] <= mk(TGT_ENABLE, 8'd0, 8'd1);
							wl_q[1] <= mk(TGT_INTENSITY, 8'd0, {1'b0, bright_q, 2'b00});
							wl_q[2] <= mk(TGT_COLOUR, ring_q,
								mode_q == MODE_MUSIC ? va_q : col_q[1]);
							wl_q[3] <= mk(TGT_COLOUR, ring_q + 8'd1,
								mode_q == MODE_MUSIC ? vb_q : col_q[0]);
							wl_q[4] <= mk(TGT_COLOUR, ring_q + 8'd2,
								mode_q == MODE_MUSIC ? vc_q : col_q[2]);
							wl_q[5] <= mk(TGT_POINTER, 8'd0, ring_q);
							wl_q[6] <= mk(TGT_TRIGGER, 8'd0, 8'd0);
							wn_q <= 4'd7;
							ring_q <= next_ring;
							if (mode_q == MODE_RAINBOW && fade_q != 8'd0)
								fade_q <= fade_q - 8'd3;
						end
						MODE_SPARKLE: begin
							wl_q[0] <= mk(TGT_ENABLE, 8'd0, 8'd1);
							wl_q[1] <= mk(TGT_INTENSITY, 8'd0, 8'h7F);
							wl_q[2] <= mk(TGT_COLOUR, ring_q, col_q[1]);
							wl_q[3] <= mk(TGT_COLOUR, ring_q + 8'd1, col_q[0]);
							wl_q[4] <= mk(TGT_COLOUR, ring_q + 8'd2, col_q[2]);
							wl_q[5] <= mk(TGT_POINTER, 8'd0, ring_q);
							ring_q <= next_ring;
						end
						default: begin
							ring_q <= '0;
							wl_q[0] <= mk(TGT_INTENSITY, 8'd0, 8'd0);
							wl_q[1] <= mk(TGT_COLOUR, 8'd0, 8'd0);
							wl_q[2] <= mk(TGT_COLOUR, 8'd1, 8'd0);
							wl_q[3] <= mk(TGT_COLOUR, 8'd2, 8'd0);
							wl_q[4] <= mk(TGT_POINTER, 8'd0, 8'd0);
							wl_q[5] <= mk(TGT_TRIGGER, 8'd0, 8'd0);
							wl_q[6] <= mk(TGT_ENABLE, 8'd0, 8'd0);
							wn_q <= 4'd7;
						end
					endcase
				end
				S_SPARK: begin
					// restore the old sparkle, light a new one, advance the LFSR
					lfsr_q <= lfsr_nx;
					sled_q <= spark_new ? lfsr_nx[7:0] : NoSparkle;
					state_q <= S_EMIT;
					if (restore) begin
						wl_q[6] <= mk(TGT_COLOUR, sled_base, bak_rd_q[23:16]);
						wl_q[7] <= mk(TGT_COLOUR, sled_base + 8'd1, bak_rd_q[15:8]);
						wl_q[8] <= mk(TGT_COLOUR, sled_base + 8'd2, bak_rd_q[7:0]);
						if (spark_new) begin
							wl_q[9] <= mk(TGT_COLOUR, new_base, 8'hFF);
							wl_q[10] <= mk(TGT_COLOUR, new_base + 8'd1, 8'hFF);
							wl_q[11] <= mk(TGT_COLOUR, new_base + 8'd2, 8'hFF);
							wl_q[12] <= mk(TGT_TRIGGER, 8'd0, 8'd0);
							wn_q <= 4'd13;
						end else begin
							wl_q[9] <= mk(TGT_TRIGGER, 8'd0, 8'd0);
							wn_q <= 4'd10;
						end
					end else if (spark_new) begin
						wl_q[6] <= mk(TGT_COLOUR, new_base, 8'hFF);
						wl_q[7] <= mk(TGT_COLOUR, new_base + 8'd1, 8'hFF);
						wl_q[8] <= mk(TGT_COLOUR, new_base + 8'd2, 8'hFF);
						wl_q[9] <= mk(TGT_TRIGGER, 8'd0, 8'd0);
						wn_q <= 4'd10;
					end else begin
						wl_q[6] <= mk(TGT_TRIGGER, 8'd0, 8'd0);
						wn_q <= 4'd7;
					end
				end
				S_EMIT: if (out_ready) begin
					if (wi_q == wn_q - 4'd1) begin
						wi_q <= '0;
						state_q <= S_IDLE;
					end else begin
						wi_q <= wi_q + 1'b1;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

>>> dv/led_strip_effect_generator_tb.sv
// Testbench for led_strip_effect_generator: drives refresh ticks and APB register
// writes, predicts each run of strip writes and checks them in order.
// Depends on lse_pkg and the RTL top level only.
`timescale 1ns / 100ps

module led_strip_effect_generator_tb;
	import lse_pkg::*;

	localparam logic [2:0] ModeJunk = 3'd7;
	localparam logic [4:0] ColorWhite = 5'd24;
	localparam int TailCycles = 80;

	// Predicts the strip writes of each tick and holds them until they arrive
	class strip_write_board;
		logic [2:0] mode;
		logic [4:0] color_idx;
		logic [1:0] tint;
		logic [4:0] bright;
		int unsigned ring, rb_step, led_mark, fade;
		logic [31:0] lfsr;
		logic [7:0] backup [LedCount][3];
		out_item_t pending [$];
		int unsigned fails;

		function new();
			mode = MODE_FIXED;
			color_idx = 5'd15;
			tint = 2'd0;
			bright = 5'd9;
			ring = 0;
			rb_step = 0;
			led_mark = 0;
			fade = 255;
			lfsr = LfsrReset;
			fails = 0;
			foreach (backup[i, j]) backup[i][j] = 8'd0;
		endfunction

		function void set_reg(logic [1:0] idx, logic [31:0] val);
			case (idx)
				REG_MODE: mode = val[2:0];
				REG_COLOR: color_idx = val[4:0];
				REG_TINT: tint = val[1:0];
				REG_BRIGHT: bright = val[4:0];
			endcase
		endfunction

		function void push_write(target_t tgt, int unsigned addr, int unsigned val);
			out_item_t w;
			w.write_target = tgt;
			w.write_address = addr[7:0];
			w.write_value = val[7:0];
			w.last_write = 1'b0;
			pending.push_back(w);
		endfunction

		// Hue wheel: returns {r, g, b}
		function void hue(int unsigned idx, int unsigned n, output int unsigned c [3]);
			int unsigned h, f;
			h = (idx * 1536) / n;
			f = h & 255;
			case (h >> 8)
				0: c = '{255, f, 0};
				1: c = '{255 - f, 255, 0};
				2: c = '{0, 255, f};
				3: c = '{0, 255 - f, 255};
				4: c = '{f, 0, 255};
				default: c = '{255, 0, 255 - f};
			endcase
		endfunction

		function void toward_white(ref int unsigned c [3], input int unsigned t);
			foreach (c[i]) c[i] = (c[i] * (255 - t) + 255 * t + 127) / 255;
		endfunction

		function int unsigned mix_of(logic [1:0] sel);
			case (sel)
				2'd0: return 0;
				2'd1: return 50;
				2'd2: return 100;
				default: return 170;
			endcase
		endfunction

		function void push_grb(int unsigned base, int unsigned c [3]);
			push_write(TGT_COLOUR, base, c[1]);
			push_write(TGT_COLOUR, base + 1, c[0]);
			push_write(TGT_COLOUR, base + 2, c[2]);
		endfunction

		function void step_ring();
			ring = (ring < 3) ? RingLast : ring - 3;
		endfunction

		// Work out the whole write run of one accepted tick
		function void note_tick(in_item_t t);
			int unsigned c [3];
			int unsigned k, first;
			first = pending.size();
			case (mode)
				MODE_FIXED: begin
					ring = 0;
					push_write(TGT_ENABLE, 0, 1);
					push_write(TGT_INTENSITY, 0, bright * 4);
					if (color_idx >= ColorWhite) c = '{255, 255, 255};
					else hue(color_idx, 24, c);
					toward_white(c, mix_of(tint));
					foreach (c[i]) c[i] = (c[i] * bright) >> 5;
					push_grb(0, c);
					push_write(TGT_POINTER, 0, 0);
					push_write(TGT_TRIGGER, 0, 0);
				end
				MODE_MUSIC: begin
					push_write(TGT_ENABLE, 0, 1);
					push_write(TGT_INTENSITY, 0, bright * 4);
					push_write(TGT_COLOUR, ring, t.voice_level_a);
					push_write(TGT_COLOUR, ring + 1, t.voice_level_b);
					push_write(TGT_COLOUR, ring + 2, t.voice_level_c);
					push_write(TGT_POINTER, 0, ring);
					step_ring();
					push_write(TGT_TRIGGER, 0, 0);
				end
				MODE_RAINBOW: begin
					push_write(TGT_ENABLE, 0, 1);
					push_write(TGT_INTENSITY, 0, bright * 4);
					rb_step = (rb_step + 1 >= 768) ? 0 : rb_step + 1;
					hue(rb_step, 768, c);
					toward_white(c, mix_of(tint));
					if (fade != 0) begin
						toward_white(c, fade);
						fade = (fade - 3) & 255;
					end
					push_grb(ring, c);
					push_write(TGT_POINTER, 0, ring);
					step_ring();
					push_write(TGT_TRIGGER, 0, 0);
				end
				MODE_SPARKLE: begin
					push_write(TGT_ENABLE, 0, 1);
					push_write(TGT_INTENSITY, 0, 'h7F);
					rb_step = (rb_step + 1 >= 768) ? 0 : rb_step + 1;
					hue(rb_step, 768, c);
					toward_white(c, mix_of(tint));
					foreach (c[i]) c[i] = (c[i] * bright) >> 5;
					k = ring / 3;
					if (k < LedCount) begin
						backup[k][0] = 8'(c[1]);
						backup[k][1] = 8'(c[0]);
						backup[k][2] = 8'(c[2]);
					end
					push_grb(ring, c);
					push_write(TGT_POINTER, 0, ring);
					step_ring();
					// restore the previous sparkle from the backup
					if (led_mark < LedCount)
						for (int i = 0; i < 3; i++)
							push_write(TGT_COLOUR, led_mark * 3 + i, backup[led_mark][i]);
					led_mark = NoSparkle;
					lfsr = lfsr[31] ? ((lfsr << 1) ^ LfsrPoly) : (lfsr << 1);
					k = lfsr & 'h1FFF;
					if (k < LedCount) begin
						led_mark = k;
						for (int i = 0; i < 3; i++) push_write(TGT_COLOUR, k * 3 + i, 255);
					end
					push_write(TGT_TRIGGER, 0, 0);
				end
				default: begin
					ring = 0;
					push_write(TGT_INTENSITY, 0, 0);
					for (int i = 0; i < 3; i++) push_write(TGT_COLOUR, i, 0);
					push_write(TGT_POINTER, 0, 0);
					push_write(TGT_TRIGGER, 0, 0);
					push_write(TGT_ENABLE, 0, 0);
				end
			endcase
			if (pending.size() > first) pending[pending.size() - 1].last_write = 1'b1;
		endfunction

		function void check(out_item_t got);
			out_item_t exp_w;
			if (pending.size() == 0) begin
				$error("unexpected write: target %0d addr %0d value %0d",
					got.write_target, got.write_address, got.write_value);
				fails++;
				return;
			end
			exp_w = pending.pop_front();
			if (got.write_target !== exp_w.write_target) begin
				$error("write_target: expected %0d, got %0d", exp_w.write_target,
					got.write_target);
				fails++;
			end
			if (got.write_address !== exp_w.write_address) begin
				$error("write_address: expected %0d, got %0d", exp_w.write_address,
					got.write_address);
				fails++;
			end
			if (got.write_value !== exp_w.write_value) begin
				$error("write_value: expected %0d, got %0d", exp_w.write_value,
					got.write_value);
				fails++;
			end
			if (got.last_write !== exp_w.last_write) begin
				$error("last_write: expected %0d, got %0d", exp_w.last_write,
					got.last_write);
				fails++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_item_t out_data;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [3:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	strip_write_board board = new();
	bit calm = 1'b0;

	led_strip_effect_generator dut (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic bit roll_idle();
		return !calm && ($urandom_range(99) < 21);
	endfunction

	// Check each accepted write and stall the sink at random
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) board.check(out_data);
		out_ready <= !roll_idle();
	end

	task automatic reg_write(logic [1:0] idx, logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		board.set_reg(idx, val);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// Hold valid until the request is taken; idle before it at random
	task automatic send_tick(in_item_t d);
		while (roll_idle()) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= d;
		do @(posedge clk); while (!in_ready);
		board.note_tick(d);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (TailCycles) @(posedge clk);
	endtask

	function automatic logic [7:0] rand_level();
		case ($urandom_range(9))
			0: return 8'd0;
			1: return 8'hFF;
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic in_item_t rand_tick();
		in_item_t d;
		d.voice_level_a = rand_level();
		d.voice_level_b = rand_level();
		d.voice_level_c = rand_level();
		return d;
	endfunction

	task automatic set_all(logic [2:0] m, logic [4:0] ci, logic [1:0] ti, logic [4:0] br);
		drain();
		reg_write(REG_MODE, 32'(m));
		reg_write(REG_COLOR, 32'(ci));
		reg_write(REG_TINT, 32'(ti));
		reg_write(REG_BRIGHT, 32'(br));
	endtask

	initial begin
		logic [2:0] m;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings first, then extremes of each effect
		send_tick('{8'h00, 8'hFF, 8'h5A});
		set_all(MODE_FIXED, 5'd0, 2'd3, 5'd31);
		send_tick('{8'hFF, 8'h00, 8'hA5});
		set_all(MODE_FIXED, 5'd23, 2'd1, 5'd0);
		send_tick(rand_tick());
		set_all(MODE_FIXED, ColorWhite, 2'd2, 5'd31);
		send_tick(rand_tick());
		set_all(MODE_FIXED, 5'd31, 2'd0, 5'd16);
		send_tick(rand_tick());
		set_all(MODE_MUSIC, 5'd0, 2'd0, 5'd31);
		send_tick('{8'hFF, 8'hFF, 8'hFF});
		send_tick('{8'h00, 8'h00, 8'h00});
		send_tick('{8'hAA, 8'h55, 8'h0F});
		set_all(MODE_OFF, 5'd0, 2'd0, 5'd0);
		send_tick(rand_tick());
		set_all(ModeJunk, 5'd12, 2'd3, 5'd31);
		send_tick(rand_tick());
		set_all(MODE_RAINBOW, 5'd0, 2'd3, 5'd31);
		repeat (4) send_tick(rand_tick());
		set_all(MODE_SPARKLE, 5'd0, 2'd0, 5'd31);
		repeat (4) send_tick(rand_tick());

		// random phases, weighted toward the stateful effects
		for (int ph = 0; ph < 12; ph++) begin
			case ($urandom_range(9))
				0: m = MODE_OFF;
				1: m = 3'($urandom_range(7, 5));
				2: m = MODE_FIXED;
				3, 4: m = MODE_MUSIC;
				5, 6: m = MODE_RAINBOW;
				default: m = MODE_SPARKLE;
			endcase
			set_all(m, 5'($urandom), 2'($urandom), 5'($urandom));
			calm = (ph == 5);
			repeat (25) send_tick(rand_tick());
			calm = 1'b0;
		end

		drain();
		if (board.fails == 0) $display("== PASS ==");
		else $display("== FAIL ==");
		$finish;
	end

	initial begin
		#20ms;
		$display("== FAIL ==");
		$finish;
	end

endmodule
